// File: rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants and types for the go-back-n sender unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Sequence numbering
  localparam int SEQ_BITS   = 16;
  localparam int MAX_WINDOW = 16;
  localparam int RESULT_CAP = 16;

  // State counters are 17 bits wide
  localparam int STATE_W = 17;
  localparam logic [STATE_W-1:0] SEQ_MASK =
    STATE_W'((64'd1 << SEQ_BITS) - 64'd1);

  // Effective window cap
  localparam int WIN_CAP_I = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;
  localparam logic [4:0] WIN_CAP = 5'(WIN_CAP_I);

  // Register reset values
  localparam logic [15:0] FRAME_COUNT_RST = 16'd0;
  localparam logic [4:0]  WINDOW_SIZE_RST = 5'd5;

  // Configuration register indexes
  localparam logic CFG_FRAME_COUNT = 1'b0;
  localparam logic CFG_WINDOW_SIZE = 1'b1;

  // Event codes
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic step;    // emit one burst frame this cycle
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;    // output register can take a result
    logic start_burst;  // current input event opens a burst
    logic step_last;    // current burst frame is the final one
  } sts_t;

endpackage

// File: rtl/go_back_n_sender_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-n sender sequencing: start, acknowledgement and timeout events in,
// sequence numbers to transmit out.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+------------------
//   in      | in_action, in_ack_number           | in_valid/in_ready
//   out     | out_send_seq/sent/last/done_res    | out_valid/out_ready
//   cfg     | cfg_index, cfg_data                | cfg_we (no wait)
//
// An acknowledgement, an ignored event or an empty burst gives one result.
// A start or timeout that opens a burst of n frames (n up to the window,
// at most 16) gives one result each: the burst sequencer emits one frame per
// cycle through the single output register unless it stalls; a stalled
// output freezes the burst until the register drains. Synchronous active-low
// reset clears counters and out_valid; frame_count resets to 0, window to 5.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_ack_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_send_seq,
  output logic        out_sent,
  output logic        out_last,
  output logic        out_done_res
);
  import gbn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  gbn_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_action     (in_action),
    .in_ack_number (in_ack_number),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_send_seq  (out_send_seq),
    .out_sent      (out_sent),
    .out_last      (out_last),
    .out_done_res  (out_done_res),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// File: rtl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp
// Datapath: configuration registers, base/next counters, burst counter and
// the output register.
// ----------------------------------------------------------------------------
module gbn_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic [1:0]     in_action,
  input  logic [15:0]    in_ack_number,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [15:0]    out_send_seq,
  output logic           out_sent,
  output logic           out_last,
  output logic           out_done_res,
  input  gbn_pkg::cmd_t  cmd,
  output gbn_pkg::sts_t  sts
);
  import gbn_pkg::*;

  logic [15:0]        frame_count_r;
  logic [4:0]         window_size_r;
  logic [STATE_W-1:0] base_r, base_nxt;
  logic [STATE_W-1:0] next_r, next_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_seq_r, out_seq_nxt;
  logic               out_sent_r, out_sent_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_done_r, out_done_nxt;

  logic [4:0]         win_eff;
  logic [STATE_W:0]   fc_ext;
  logic               is_done;
  logic               ack_match;
  logic [STATE_W-1:0] base_inc;
  logic [STATE_W-1:0] next_inc;
  logic               start_burst;

  // Effective window and common compares
  assign win_eff   = (window_size_r > WIN_CAP) ? WIN_CAP : window_size_r;
  assign fc_ext    = {2'b00, frame_count_r};
  assign is_done   = {1'b0, base_r} >= fc_ext;
  assign ack_match = {1'b0, in_ack_number} == (base_r & SEQ_MASK);
  assign base_inc  = base_r + 1'b1;
  assign next_inc  = next_r + 1'b1;

  // Status to controller
  assign sts.slot_free   = !out_valid_r || out_ready;
  assign sts.step_last   = ((cnt_r + 5'd1) == win_eff) ||
                           ({1'b0, next_r} + 1'b1 >= fc_ext);
  assign sts.start_burst = start_burst;
  always_comb begin
    start_burst = 1'b0;
    if (in_action == ACT_START) begin
      start_burst = (win_eff != 5'd0) && (frame_count_r != 16'd0);
    end else if (in_action == ACT_TIMEOUT) begin
      start_burst = !is_done && (win_eff != 5'd0);
    end
  end

  // Next-state logic for counters and output register
  always_comb begin
    base_nxt      = base_r;
    next_nxt      = next_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_seq_nxt   = out_seq_r;
    out_sent_nxt  = out_sent_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;

    if (cmd.accept) begin
      cnt_nxt = 5'd0;
      // default: status-only result with state after the event
      out_seq_nxt  = 16'd0;
      out_sent_nxt = 1'b0;
      out_last_nxt = 1'b1;
      out_done_nxt = is_done;
      case (in_action)
        ACT_START: begin
          base_nxt     = '0;
          next_nxt     = '0;
          out_done_nxt = (frame_count_r == 16'd0);
        end
        ACT_ACK: begin
          if (!is_done && ack_match) begin
            base_nxt     = base_inc;
            next_nxt     = next_inc;
            out_done_nxt = {1'b0, base_inc} >= fc_ext;
            if ({1'b0, next_r} < fc_ext) begin
              out_sent_nxt = 1'b1;
              out_seq_nxt  = 16'(next_r & SEQ_MASK);
            end
          end
        end
        ACT_TIMEOUT: begin
          if (!is_done) begin
            next_nxt = base_r;
          end
        end
        default: begin
        end
      endcase
      out_valid_nxt = !start_burst;
    end else if (cmd.step) begin
      // one burst frame
      out_valid_nxt = 1'b1;
      out_seq_nxt   = 16'(next_r & SEQ_MASK);
      out_sent_nxt  = 1'b1;
      out_last_nxt  = sts.step_last;
      out_done_nxt  = is_done;
      next_nxt      = next_inc;
      cnt_nxt       = cnt_r + 5'd1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      window_size_r <= WINDOW_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT: frame_count_r <= cfg_data;
        CFG_WINDOW_SIZE: window_size_r <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      next_r      <= '0;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_seq_r  <= out_seq_nxt;
    out_sent_r <= out_sent_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_send_seq = out_seq_r;
  assign out_sent     = out_sent_r;
  assign out_last     = out_last_r;
  assign out_done_res = out_done_r;

  // Checks
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> ({1'b0, next_r} < fc_ext) && (cnt_r < win_eff))
    else $error("burst step beyond frame count or window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept || cmd.step) |-> sts.slot_free)
    else $error("output register overwritten while held");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_seq_r) &&
                                    $stable(out_last_r))
    else $error("pending result lost or changed");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.step))
    else $error("accept and burst step in same cycle");

endmodule

// File: rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Controller: takes events and sequences bursts one frame per cycle while the output register is free.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output gbn_pkg::cmd_t  cmd,
  input  gbn_pkg::sts_t  sts
);
  import gbn_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_BURST = 1'b1;

  logic state_r, state_nxt;

  // Handshake and commands
  assign in_ready   = (state_r == S_IDLE) && sts.slot_free;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state_r == S_BURST) && sts.slot_free;

  // State transitions
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.start_burst) state_nxt = S_BURST;
      end
      S_BURST: begin
        if (cmd.step && sts.step_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> state_r == S_IDLE)
    else $error("event taken during burst");

  a_burst_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.start_burst) |=> state_r == S_BURST)
    else $error("burst not started");

  a_burst_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.step_last) |=> state_r == S_IDLE)
    else $error("burst did not end on last frame");

endmodule
